/* src/cbm_pkg.sv */
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

	localparam int RAM_DEPTH = 256;
	localparam int RAM_AW    = $clog2(RAM_DEPTH);
	localparam int BANK_W    = 6;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// Request codes
	localparam logic [1:0] REQ_REG_WR = 2'd0;
	localparam logic [1:0] REQ_RAM_RD = 2'd1;
	localparam logic [1:0] REQ_RAM_WR = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_EXROM = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_GAME = 2'd3;

	// Hardware type codes
	localparam logic [15:0] TYPE_FLASH = 16'd32;
	localparam logic [15:0] TYPE_MDESK = 16'd19;
	localparam logic [15:0] TYPE_ADDRB = 16'd15;

	// Mapped bank and line levels
	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic              exrom;
		logic              game;
	} map_state_t;

	// Result of one access, held between the two pipeline registers
	typedef struct packed {
		map_state_t map;
		logic       bank_load;
		logic       rd_hit;
	} stage_t;

endpackage

/* src/cbm_if.sv */
// ----------------------------------------------------------------------------
// cbm_req_if / cbm_rsp_if
// Valid/ready channels for bus accesses and their results.
// ----------------------------------------------------------------------------
interface cbm_req_if;
	import cbm_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [BYTE_W-1:0] addr;
	logic [BYTE_W-1:0] data;

	modport source (output valid, output req_type, output addr, output data, input ready);
	modport sink   (input valid, input req_type, input addr, input data, output ready);
endinterface

interface cbm_rsp_if;
	import cbm_pkg::*;
	logic              valid;
	logic              ready;
	logic [BANK_W-1:0] bank;
	logic              bank_load;
	logic              exrom_line;
	logic              game_line;
	logic [BYTE_W-1:0] read_data;

	modport source (output valid, output bank, output bank_load, output exrom_line,
		output game_line, output read_data, input ready);
	modport sink   (input valid, input bank, input bank_load, input exrom_line,
		input game_line, input read_data, output ready);
endinterface

/* src/cbm_ram.sv */
// ----------------------------------------------------------------------------
// cbm_ram
// Generic single-clock RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/cbm_decode.sv */
// ----------------------------------------------------------------------------
// cbm_decode
// Register-write rule: next bank and line levels for one I/O-1 write.
// ----------------------------------------------------------------------------
module cbm_decode import cbm_pkg::*; (
	input  map_state_t        cur,
	input  logic              cart_active,
	input  logic [15:0]       cart_type,
	input  logic [BYTE_W-1:0] addr,
	input  logic [BYTE_W-1:0] data,
	output map_state_t        nxt,
	output logic              bank_load
);

	logic              sel;
	logic [BANK_W-1:0] sel_bank;

	always_comb begin
		nxt      = cur;
		sel      = 1'b0;
		sel_bank = data[BANK_W-1:0];
		if (cart_active) begin
			if (cart_type == TYPE_FLASH) begin
				if (!addr[1]) begin
					sel = 1'b1;
				end else begin
					nxt.exrom = ~data[1];
					nxt.game  = data[2] ? ~data[0] : 1'b0;
				end
			end else if (cart_type == TYPE_MDESK) begin
				// bit 7 unmaps the ROM and keeps the bank
				if (data[7]) begin
					nxt.exrom = 1'b1;
				end else begin
					nxt.exrom = 1'b0;
					sel       = 1'b1;
				end
			end else if (cart_type == TYPE_ADDRB) begin
				sel      = 1'b1;
				sel_bank = addr[BANK_W-1:0];
			end else begin
				sel = 1'b1;
			end
		end
		if (sel) begin
			nxt.bank = sel_bank;
		end
	end

	assign bank_load = sel && (sel_bank != cur.bank);

endmodule

/* src/cartridge_bank_mapper.sv */
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Cartridge bank mapper: register writes select a ROM bank and drive the
// EXROM/GAME lines; a 256-byte RAM in the I/O-2 page is read and written.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      beat contents
//   -------   ---   ------------   -----------------------------------------
//   req       in    valid/ready    req_type, addr, data
//   rsp       out   valid/ready    bank, bank_load, exrom_line, game_line,
//                                  read_data
//   cfg       in    cfg_we only    cfg_index, cfg_data (16 bit)
//
// One beat a cycle is accepted unless rsp stalls with the pipe full; each
// request's result passes the RAM read stage, then the output register.
// Reset sets the mapping state and registers to their reset values and
// clears all RAM valid bits at once, so no clearing pass is needed; mounting
// a type 32 cartridge clears the valid bits likewise. Unwritten RAM entries
// read as zero. A stall on rsp holds the output register and then the first
// stage; req is refused only when both hold a beat and rsp is not taking one.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper import cbm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	cbm_req_if.sink               req,
	cbm_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic        active_q;
	logic [15:0] type_q;
	logic        init_exrom_q;
	logic        init_game_q;

	// mapping state and RAM entry valid bits
	map_state_t           map_q;
	logic [RAM_DEPTH-1:0] ram_vld_q;

	// pipeline
	logic              vld_s1;
	stage_t            st_s1;
	logic              vld_s2;
	stage_t            st_s2;
	logic [BYTE_W-1:0] rdata_s2;

	logic              accept;
	logic              adv_s1;
	logic              is_reg;
	logic              is_rd;
	logic              is_wr;
	map_state_t        dec_nxt;
	logic              dec_load;
	logic [BYTE_W-1:0] ram_rdata;
	logic [RAM_AW-1:0] ram_addr;

	assign adv_s1    = !vld_s2 || rsp.ready;
	assign req.ready = !vld_s1 || adv_s1;
	assign accept    = req.valid && req.ready;
	assign is_reg    = req.req_type == REQ_REG_WR;
	assign is_rd     = req.req_type == REQ_RAM_RD;
	assign is_wr     = req.req_type == REQ_RAM_WR;
	assign ram_addr  = req.addr[RAM_AW-1:0];

	cbm_decode u_decode (
		.cur         (map_q),
		.cart_active (active_q),
		.cart_type   (type_q),
		.addr        (req.addr),
		.data        (req.data),
		.nxt         (dec_nxt),
		.bank_load   (dec_load)
	);

	cbm_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (accept && is_wr),
		.waddr (ram_addr),
		.wdata (req.data),
		.re    (accept && is_rd),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	// Configuration writes and state updates. Writes must come only while idle,
	// so they never meet an accepted beat; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			type_q       <= '0;
			init_exrom_q <= 1'b1;
			init_game_q  <= 1'b1;
			map_q        <= '{bank: '0, exrom: 1'b1, game: 1'b1};
			ram_vld_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE: begin
					active_q <= cfg_data[0];
					map_q.bank <= '0;
					if (!cfg_data[0]) begin
						map_q.exrom <= 1'b1;
						map_q.game  <= 1'b1;
					end else if (type_q == TYPE_FLASH) begin
						// mount with flash type: lines fixed, RAM wiped
						map_q.exrom <= 1'b1;
						map_q.game  <= 1'b0;
						ram_vld_q   <= '0;
					end else begin
						map_q.exrom <= init_exrom_q;
						map_q.game  <= init_game_q;
					end
				end
				CFG_TYPE:       type_q       <= cfg_data;
				CFG_INIT_EXROM: init_exrom_q <= cfg_data[0];
				CFG_INIT_GAME:  init_game_q  <= cfg_data[0];
				default: ;
			endcase
		end else if (accept) begin
			if (is_reg) begin
				map_q <= dec_nxt;
			end
			if (is_wr) begin
				ram_vld_q[ram_addr] <= 1'b1;
			end
		end
	end

	// First stage: state after the access, RAM read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1.map       <= is_reg ? dec_nxt : map_q;
			st_s1.bank_load <= is_reg && dec_load;
			st_s1.rd_hit    <= is_rd && ram_vld_q[ram_addr];
		end
	end

	// Output register: hold while rsp stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (vld_s1 && adv_s1) begin
			vld_s2 <= 1'b1;
		end else if (rsp.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && adv_s1) begin
			st_s2    <= st_s1;
			rdata_s2 <= st_s1.rd_hit ? ram_rdata : '0;
		end
	end

	assign rsp.valid      = vld_s2;
	assign rsp.bank       = st_s2.map.bank;
	assign rsp.bank_load  = st_s2.bank_load;
	assign rsp.exrom_line = st_s2.map.exrom;
	assign rsp.game_line  = st_s2.map.game;
	assign rsp.read_data  = rdata_s2;

	// A RAM write marks its entry valid
	a_wr_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_wr) |=> ram_vld_q[$past(ram_addr)])
		else $error("RAM write did not mark its entry valid");

	// No bank change while unmounted
	a_unmounted_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_reg && !active_q) |=> !st_s1.bank_load)
		else $error("bank load while no cartridge mounted");

	// With bit 7 clear the disabling type always drives EXROM low after a load
	a_mdesk_load: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && st_s1.bank_load && type_q == TYPE_MDESK) |-> !st_s1.map.exrom)
		else $error("bank load with EXROM inactive");

	// A first-stage beat is never dropped while the output stalls
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv_s1) |=> vld_s1 && $stable(st_s1))
		else $error("first stage lost a beat under stall");

endmodule

/* tb/sv/bank_map_checker.sv */
// ----------------------------------------------------------------------------
// bank_map_checker
// Watches the access and result channels and the register port of the
// cartridge bank mapper, keeps its own image of the mapping state and the
// cartridge RAM, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module bank_map_checker import cbm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	cbm_req_if                    req,
	cbm_rsp_if                    rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Bits of the written byte (or address) that the banking rules look at
	localparam logic [BYTE_W-1:0] FLASH_CTRL_SEL  = 8'h02;
	localparam logic [BYTE_W-1:0] FLASH_EXROM_BIT = 8'h02;
	localparam logic [BYTE_W-1:0] FLASH_GAME_EN   = 8'h04;
	localparam logic [BYTE_W-1:0] FLASH_GAME_BIT  = 8'h01;
	localparam logic [BYTE_W-1:0] MDESK_OFF_BIT   = 8'h80;

	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic              bank_load;
		logic              exrom;
		logic              game;
		logic [BYTE_W-1:0] read_data;
	} access_result_t;

	logic                  mounted;
	logic [CFG_DATA_W-1:0] cart_kind;
	logic                  start_exrom;
	logic                  start_game;
	logic [BANK_W-1:0]     mapped_bank;
	logic                  exrom_lvl;
	logic                  game_lvl;
	logic [BYTE_W-1:0]     ram_image [RAM_DEPTH];
	access_result_t        expected_results [$];

	function automatic logic map_bank(input logic [BYTE_W-1:0] sel);
		logic [BANK_W-1:0] nb;
		logic              changed;
		nb = sel[BANK_W-1:0];
		changed = (nb != mapped_bank);
		mapped_bank = nb;
		return changed;
	endfunction

	function automatic logic register_write(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] d);
		if (!mounted)
			return 1'b0;
		if (cart_kind == TYPE_FLASH) begin
			if ((a & FLASH_CTRL_SEL) == '0)
				return map_bank(d);
			exrom_lvl = ~|(d & FLASH_EXROM_BIT);
			game_lvl  = |(d & FLASH_GAME_EN) ? ~|(d & FLASH_GAME_BIT) : 1'b0;
			return 1'b0;
		end
		if (cart_kind == TYPE_MDESK) begin
			// top bit unmaps the ROM and keeps the bank
			if (|(d & MDESK_OFF_BIT)) begin
				exrom_lvl = 1'b1;
				return 1'b0;
			end
			exrom_lvl = 1'b0;
			return map_bank(d);
		end
		if (cart_kind == TYPE_ADDRB)
			return map_bank(a);
		return map_bank(d);
	endfunction

	function automatic access_result_t predict_access(input logic [1:0] kind,
		input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] d);
		access_result_t r;
		r = '0;
		case (kind)
			REQ_REG_WR: r.bank_load = register_write(a, d);
			REQ_RAM_RD: r.read_data = ram_image[a];
			REQ_RAM_WR: ram_image[a] = d;
			default: ;
		endcase
		r.bank  = mapped_bank;
		r.exrom = exrom_lvl;
		r.game  = game_lvl;
		return r;
	endfunction

	task automatic clear_ram();
		for (int i = 0; i < RAM_DEPTH; i++)
			ram_image[i] = '0;
	endtask

	task automatic reset_model();
		mounted     = 1'b0;
		cart_kind   = '0;
		start_exrom = 1'b1;
		start_game  = 1'b1;
		mapped_bank = '0;
		exrom_lvl   = 1'b1;
		game_lvl    = 1'b1;
		clear_ram();
	endtask

	task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		case (idx)
			CFG_ACTIVE: begin
				mounted     = value[0];
				mapped_bank = '0;
				if (!mounted) begin
					exrom_lvl = 1'b1;
					game_lvl  = 1'b1;
				end else if (cart_kind == TYPE_FLASH) begin
					exrom_lvl = 1'b1;
					game_lvl  = 1'b0;
					clear_ram();
				end else begin
					exrom_lvl = start_exrom;
					game_lvl  = start_game;
				end
			end
			CFG_TYPE:       cart_kind   = value;
			CFG_INIT_EXROM: start_exrom = value[0];
			CFG_INIT_GAME:  start_game  = value[0];
			default: ;
		endcase
	endtask

	task automatic check_field(input string what, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	task automatic compare_result();
		access_result_t want;
		if (expected_results.size() == 0) begin
			mismatches++;
			$display("%0t: result expected none, got bank %0d load %0b exrom %0b game %0b data %0d",
				$time, rsp.bank, rsp.bank_load, rsp.exrom_line, rsp.game_line, rsp.read_data);
			return;
		end
		want = expected_results.pop_front();
		check_field("bank", want.bank, rsp.bank);
		check_field("bank_load", want.bank_load, rsp.bank_load);
		check_field("exrom_line", want.exrom, rsp.exrom_line);
		check_field("game_line", want.game, rsp.game_line);
		check_field("read_data", want.read_data, rsp.read_data);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
			expected_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				apply_register(cfg_index, cfg_data);
			if (rsp.valid && rsp.ready)
				compare_result();
			if (req.valid && req.ready)
				expected_results.push_back(predict_access(req.req_type, req.addr, req.data));
			pending <= expected_results.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the cartridge bank mapper: directed and random bus accesses
// under every cartridge type, with random idling on both channels, a long
// result stall and register changes between phases. Checking is done by
// bank_map_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cbm_pkg::*;

	// Request code that the block must ignore
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	// Request to result, in cycles
	localparam int PIPE_LATENCY    = 2;
	localparam int IDLE_PCT        = 36;
	localparam int RSP_HOLD_CYCLES = 60;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    pending;

	// Shared between the stimulus and the result sink; holds_served is used by the sink only
	bit no_idle      = 1'b0;
	int hold_asks    = 0;
	int holds_served = 0;

	cbm_req_if req_ch ();
	cbm_rsp_if rsp_ch ();

	cartridge_bank_mapper u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bank_map_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	// Reset once at the start
	initial begin
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Give up if the run hangs
	initial begin : watchdog
		#3ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Result sink: random back-pressure, or a long hold-off when the stimulus
	// asks for one, counted here in cycles
	initial begin : result_sink
		forever begin
			if (hold_asks != holds_served) begin
				rsp_ch.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(posedge clk);
				holds_served++;
			end else begin
				rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
				@(posedge clk);
			end
		end
	end

	// Offer one access beat, idling first at random, and hold it until taken.
	// Valid stays high on return so back-to-back beats need no re-assert.
	task automatic send_access(input logic [1:0] kind, input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] d);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.addr     <= a;
		req_ch.data     <= d;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Random beats. Half the addresses fall in a small window so that RAM
	// reads mostly hit bytes written earlier in the phase.
	task automatic send_random(input int count);
		int                pick;
		logic [1:0]        kind;
		logic [BYTE_W-1:0] a;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				kind = REQ_REG_WR;
			else if (pick < 65)
				kind = REQ_RAM_RD;
			else if (pick < 92)
				kind = REQ_RAM_WR;
			else
				kind = REQ_UNUSED;
			a = $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
			send_access(kind, a, 8'($urandom_range(255)));
		end
	endtask

	// Drop valid and hold until every predicted result has come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Registers only change with the pipe empty. Upper data bits of the
	// one-bit registers are random and must be dropped by the block.
	task automatic reconfigure(input logic [CFG_DATA_W-1:0] kind, input logic ie, input logic ig);
		drain_results();
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		write_reg(CFG_TYPE, kind);
		write_reg(CFG_INIT_EXROM, {15'($urandom), ie});
		write_reg(CFG_INIT_GAME, {15'($urandom), ig});
		write_reg(CFG_ACTIVE, {15'($urandom), 1'b1});
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		req_ch.valid    <= 1'b0;
		req_ch.req_type <= REQ_RAM_RD;
		req_ch.addr     <= '0;
		req_ch.data     <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= CFG_ACTIVE;
		cfg_data        <= '0;
		do @(posedge clk); while (!arst_n);

		// Unmounted: RAM works at both ends, register writes and the unused
		// request code change nothing
		send_access(REQ_RAM_RD, 8'h00, 8'hff);
		send_access(REQ_RAM_RD, 8'hff, 8'h00);
		send_access(REQ_RAM_WR, 8'h00, 8'hff);
		send_access(REQ_RAM_WR, 8'hff, 8'h00);
		send_access(REQ_RAM_RD, 8'h00, 8'h00);
		send_access(REQ_RAM_RD, 8'hff, 8'hff);
		send_access(REQ_REG_WR, 8'hff, 8'hff);
		send_access(REQ_UNUSED, 8'haa, 8'h55);
		send_random(60);

		// Separate bank and control registers; mounting clears the RAM
		reconfigure(TYPE_FLASH, 1'b0, 1'b0);
		send_access(REQ_RAM_RD, 8'h00, 8'h00);
		send_access(REQ_REG_WR, 8'h00, 8'h3f);
		send_access(REQ_REG_WR, 8'h00, 8'hff);
		send_access(REQ_REG_WR, 8'hfd, 8'h00);
		send_access(REQ_REG_WR, 8'h02, 8'h07);
		send_access(REQ_REG_WR, 8'h02, 8'h05);
		send_access(REQ_REG_WR, 8'hff, 8'h04);
		send_access(REQ_REG_WR, 8'h02, 8'h02);
		send_access(REQ_REG_WR, 8'h02, 8'h00);
		send_access(REQ_REG_WR, 8'h02, 8'hff);
		send_access(REQ_UNUSED, 8'h55, 8'haa);
		send_random(130);

		// Top data bit unmaps the ROM and keeps the bank
		reconfigure(TYPE_MDESK, 1'b0, 1'b0);
		send_access(REQ_REG_WR, 8'h00, 8'h3f);
		send_access(REQ_REG_WR, 8'h00, 8'h80);
		send_access(REQ_REG_WR, 8'h00, 8'hff);
		send_access(REQ_REG_WR, 8'h00, 8'h00);
		send_access(REQ_REG_WR, 8'h00, 8'h7f);
		// Stall the result side for a long stretch while beats keep coming,
		// so the pipe fills and the request side backs up
		hold_asks++;
		send_random(120);

		// Bank from the address bits; no idling on either side here, and one
		// pause in the middle until the pipe is empty
		reconfigure(TYPE_ADDRB, 1'b1, 1'b0);
		no_idle = 1'b1;
		send_access(REQ_REG_WR, 8'hff, 8'h00);
		send_access(REQ_REG_WR, 8'hc0, 8'hff);
		send_access(REQ_REG_WR, 8'h3f, 8'h3f);
		send_random(60);
		drain_results();
		send_random(60);
		no_idle = 1'b0;

		// Data banking for any other type, at both ends of the type range
		reconfigure(16'hffff, 1'b0, 1'b1);
		send_random(100);
		reconfigure(16'h0000, 1'b1, 1'b1);
		send_random(60);

		// Remount the flash type: bytes written above must read back as zero
		reconfigure(TYPE_FLASH, 1'b1, 1'b1);
		send_access(REQ_RAM_RD, 8'h00, 8'h00);
		send_access(REQ_RAM_RD, 8'h0f, 8'h00);
		send_access(REQ_RAM_RD, 8'hff, 8'h00);
		send_random(60);

		// Unmount: both lines inactive, bank 0, register writes ignored
		drain_results();
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		write_reg(CFG_ACTIVE, {15'($urandom), 1'b0});
		cfg_we <= 1'b0;
		send_random(60);

		drain_results();
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* files.f */
src/cbm_pkg.sv
src/cbm_if.sv
src/cbm_ram.sv
src/cbm_decode.sv
src/cartridge_bank_mapper.sv
tb/sv/bank_map_checker.sv
tb/sv/tb.sv
